FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_W          = 16;
   localparam int KEY_W         = 16;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic                load;
      logic                insert;
      logic                pop;
      logic [STATUS_W-1:0] code;
   } spq_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } spq_stat_type;

endpackage

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue of (id, key) entries.
//
// Request channel (req_*): req_mode 0 inserts (req_entry_id, req_entry_key),
// req_mode 1 pops the entry with the smallest key, oldest first among ties.
// Result channel (rsp_*): one item per request with rsp_status (ok, insert
// dropped because full, pop on empty), the popped id and key (zero unless a
// pop succeeded) and the occupancy after the request.
// rsp_valid rises in the cycle after a request is accepted. One request is
// taken every cycle while the receiver takes results: the entries sit in a
// row of DEPTH compare-and-shift cells that all compare against the new key
// in the same cycle and shift in one step. The result register lets the next
// request enter in the cycle in which the previous result is taken.
// Reset empties the queue and drops any held result; no clearing pass runs.
// If the receiver stalls, the result is held and req_ready falls until
// rsp_ready returns.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic [KEY_W-1:0]    req_entry_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_entry_id  (req_entry_id),
      .req_entry_key (req_entry_key),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_key   (rsp_out_key),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

FILE: rtl/spq_ctrl.sv
// Controller: handshake, result hold state and operation decode.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_mode,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  spq_stat_type stat,
   output spq_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_HOLD);

   always_comb begin
      cmd.load   = accept;
      cmd.insert = accept && !req_mode && !stat.full;
      cmd.pop    = accept && req_mode && !stat.empty;
      if (req_mode) begin
         cmd.code = stat.empty ? STAT_EMPTY : STAT_OK;
      end else begin
         cmd.code = stat.full ? STAT_FULL : STAT_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!accept && rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/spq_datapath.sv
// Datapath: sorted compare-and-shift cells, fill count and result register.
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  spq_cmd_type         cmd,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic [KEY_W-1:0]    req_entry_key,
   output spq_stat_type        stat,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_out_id,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [ID_W-1:0]        id_ff  [DEPTH];
   logic [KEY_W-1:0]       key_ff [DEPTH];
   logic [DEPTH-1:0]       gt;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W+OCC_W-1:0] count_ext;

   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [KEY_W-1:0]    out_key_ff;
   logic [OCC_W-1:0]    occ_ff;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) count_in = count_ff + CNT_W'(1);
      else if (cmd.pop) count_in = count_ff - CNT_W'(1);
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};

   // Stored keys are ascending, so the strictly-greater flags form a run that
   // ends at the fill count; the new entry lands at the start of that run.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic here;
      logic prev_gt;

      assign gt[i] = (IDX < count_ff) && (key_ff[i] > req_entry_key);

      if (i == 0) begin : g_first
         assign prev_gt = 1'b0;
      end else begin : g_rest
         assign prev_gt = gt[i-1];
      end

      assign here = !prev_gt && (gt[i] || (IDX == count_ff));

      always_ff @(posedge clock) begin
         if (cmd.insert) begin
            if (prev_gt) begin
               if (i > 0) begin
                  id_ff[i]  <= id_ff[(i > 0) ? i - 1 : 0];
                  key_ff[i] <= key_ff[(i > 0) ? i - 1 : 0];
               end
            end else if (here) begin
               id_ff[i]  <= req_entry_id;
               key_ff[i] <= req_entry_key;
            end
         end else if (cmd.pop) begin
            if (i < DEPTH - 1) begin
               id_ff[i]  <= id_ff[(i < DEPTH - 1) ? i + 1 : i];
               key_ff[i] <= key_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff  <= cmd.code;
         out_id_ff  <= cmd.pop ? id_ff[0] : '0;
         out_key_ff <= cmd.pop ? key_ff[0] : '0;
         occ_ff     <= count_ext[OCC_W-1:0];
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_out_id    = out_id_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_occupancy = occ_ff;

endmodule

FILE: rtl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_port_assertions
   import spq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ID_W-1:0]     rsp_out_id,
   input logic [KEY_W-1:0]    rsp_out_key,
   input logic [OCC_W-1:0]    rsp_occupancy
);

   // A result that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_id) && $stable(rsp_out_key) && $stable(rsp_occupancy))
      else $error("result item changed while stalled");

   // A pop on an empty queue leaves it empty.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_occupancy == '0)
      else $error("empty pop reported nonzero occupancy");

   // A failed request carries no entry.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_out_id == '0 && rsp_out_key == '0)
      else $error("failed item carried entry data");

   // A new item enters while a result is held only if that result leaves at the same edge.
   a_req_while_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_ready)
      else $error("request item accepted while a result was stalled");

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind sorted_priority_queue spq_port_assertions u_spq_port_assertions (.*);
